>>> hdl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Fixed types, status codes and register indexes shared by the PID block.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int FracBits = 16;

   typedef enum logic [2:0] {
      ST_COMPUTED = 3'd0,
      ST_DISABLED = 3'd1,
      ST_FIRST    = 3'd2,
      ST_ZERO_DT  = 3'd3,
      ST_RESET    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_PROP   = 3'd0,
      REG_INTEG  = 3'd1,
      REG_DERIV  = 3'd2,
      REG_TARGET = 3'd3,
      REG_LOWER  = 3'd4,
      REG_UPPER  = 3'd5,
      REG_ENABLE = 3'd6,
      REG_ANGLE  = 3'd7
   } reg_index_type;

   // Request to the shared multiply/divide unit: round(a*b/d), saturated.
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] d;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } md_rsp_type;

   typedef struct packed {
      logic        op;
      logic [31:0] feedback;
      logic [31:0] time_us;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] drive;
      logic [2:0]  status;
   } rsp_payload_type;

endpackage

>>> hdl/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// PID controller with integral anti-windup
// Fixed-point PID loop with clamped integral and derivative on measurement.
// ----------------------------------------------------------------------------
// One request item is taken at a time. Reset commands, disabled samples,
// first samples and zero-interval samples present their result on the cycle
// after the item is taken. A computed sample runs its round(a*b/d) operations
// through one shared multiply-divide unit. Each operation passes from launch
// to done through the multiply by partial products, the rounding step, the
// bit-by-bit division, the finish step and the result register. With a
// nonzero integral gain there are seven operations (integral step, both
// accumulator limits, integral term, derivative, proportional and derivative
// gain products); with a zero integral gain the two limit divisions drop.
// In angular mode each of the two wrap passes folds its value by a full turn
// per step until the value settles inside +/-180. The request side stalls
// for the whole time. The result sits in an output register; the next
// request is taken on the cycle after it is gone.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
   import pidc_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 1000000
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [31:0]     csr_data
);

   localparam logic [63:0] Ticks    = 64'(TICKS_PER_SECOND);
   localparam logic [63:0] One      = 64'd1 << FracBits;
   localparam logic [63:0] HalfTurn = 64'd180 << FracBits;
   localparam logic [63:0] FullTurn = 64'd360 << FracBits;
   localparam logic [63:0] NoCap    = 64'd1000000000000 << FracBits;
   localparam logic [63:0] SMax     = {1'b0, {63{1'b1}}};
   localparam logic [63:0] SMin     = {1'b1, 63'd0};

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_ERR   = 14'b00000000000010,
      S_WRAPE = 14'b00000000000100,
      S_MINT  = 14'b00000000001000,
      S_ACC   = 14'b00000000010000,
      S_MAXI  = 14'b00000000100000,
      S_MINI  = 14'b00000001000000,
      S_CLMP  = 14'b00000010000000,
      S_ITRM  = 14'b00000100000000,
      S_WRAPD = 14'b00001000000000,
      S_DER   = 14'b00010000000000,
      S_PROP  = 14'b00100000000000,
      S_DGN   = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   // configuration
   logic [23:0] kp_ff, ki_ff, kd_ff;
   logic [31:0] target_ff, lower_ff, upper_ff;
   logic        enable_ff, angle_ff;

   // controller state
   logic [63:0] acc_ff, acc_in;
   logic [31:0] pstamp_ff, pstamp_in;
   logic [31:0] pmeas_ff, pmeas_in;
   logic        have_ff, have_in;
   logic [31:0] last_ff, last_in;

   // work registers
   state_type   state_ff, state_in;
   logic        wait_ff, wait_in;
   logic [31:0] fb_ff, fb_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] delta_ff, delta_in;
   logic [63:0] err_ff, err_in;
   logic [63:0] dm_ff, dm_in;
   logic [63:0] maxi_ff, maxi_in;
   logic [63:0] mini_ff, mini_in;
   logic [63:0] iterm_ff, iterm_in;
   logic [63:0] deriv_ff, deriv_in;
   logic [63:0] sum_ff, sum_in;
   logic        rvalid_ff, rvalid_in;
   rsp_payload_type rdata_ff, rdata_in;

   md_req_type md_req;
   md_rsp_type md_rsp;

   logic [63:0] lo64, hi64;
   logic [63:0] wrap_x, wrap_y;
   logic [63:0] add_a, add_b, add_r;
   logic        add_sub;
   logic [63:0] clmp_r;
   logic        accept;

   pidc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign lo64 = {{32{lower_ff[31]}}, lower_ff};
   assign hi64 = {{32{upper_ff[31]}}, upper_ff};

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rvalid_ff;
   assign csr_ready = 1'b1;

   // One wrap step per cycle: fold by a full turn toward +/-180 until inside.
   always_comb begin
      wrap_x = (state_ff == S_WRAPE) ? err_ff : dm_ff;
      if ($signed(wrap_x) > $signed(HalfTurn)) begin
         wrap_y = wrap_x - FullTurn;
      end else if ($signed(wrap_x) < -$signed(HalfTurn)) begin
         wrap_y = wrap_x + FullTurn;
      end else begin
         wrap_y = wrap_x;
      end
   end

   // Shared saturating adder.
   always_comb begin
      add_r = add_sub ? (add_a - add_b) : (add_a + add_b);
      if (!add_sub && (add_a[63] == add_b[63]) && (add_r[63] != add_a[63])) begin
         add_r = add_a[63] ? SMin : SMax;
      end else if (add_sub && (add_a[63] != add_b[63]) && (add_r[63] != add_a[63])) begin
         add_r = add_a[63] ? SMin : SMax;
      end
   end

   always_comb begin
      add_a   = acc_ff;
      add_b   = md_rsp.q;
      add_sub = 1'b0;
      case (state_ff)
         S_DER: begin
            add_a = md_rsp.q;
            add_b = iterm_ff;
         end
         S_DGN: begin
            add_a   = sum_ff;
            add_b   = md_rsp.q;
            add_sub = 1'b1;
         end
         default: ;
      endcase
   end

   // Final clamp of the sum: below the lower bound first, then above the upper.
   always_comb begin
      if ($signed(add_r) < $signed(lo64)) begin
         clmp_r = lo64;
      end else if ($signed(add_r) > $signed(hi64)) begin
         clmp_r = hi64;
      end else begin
         clmp_r = add_r;
      end
   end

   always_comb begin
      state_in  = state_ff;
      wait_in   = 1'b0;
      fb_in     = fb_ff;
      now_in    = now_ff;
      delta_in  = delta_ff;
      err_in    = err_ff;
      dm_in     = dm_ff;
      maxi_in   = maxi_ff;
      mini_in   = mini_ff;
      iterm_in  = iterm_ff;
      deriv_in  = deriv_ff;
      sum_in    = sum_ff;
      acc_in    = acc_ff;
      pstamp_in = pstamp_ff;
      pmeas_in  = pmeas_ff;
      have_in   = have_ff;
      last_in   = last_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      rdata_in  = rdata_ff;
      md_req    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fb_in    = req_payload.feedback;
               now_in   = req_payload.time_us;
               delta_in = req_payload.time_us - pstamp_ff;
               if (req_payload.op) begin
                  acc_in    = '0;
                  have_in   = 1'b0;
                  rvalid_in = 1'b1;
                  rdata_in  = '{drive: 32'd0, status: ST_RESET};
               end else if (!enable_ff) begin
                  rvalid_in = 1'b1;
                  rdata_in  = '{drive: 32'd0, status: ST_DISABLED};
               end else if (!have_ff) begin
                  pstamp_in = req_payload.time_us;
                  pmeas_in  = req_payload.feedback;
                  have_in   = 1'b1;
                  rvalid_in = 1'b1;
                  rdata_in  = '{drive: 32'd0, status: ST_FIRST};
               end else if (req_payload.time_us == pstamp_ff) begin
                  rvalid_in = 1'b1;
                  rdata_in  = '{drive: last_ff, status: ST_ZERO_DT};
               end else begin
                  state_in = S_ERR;
               end
            end
         end
         S_ERR: begin
            err_in   = {{32{target_ff[31]}}, target_ff} - {{32{fb_ff[31]}}, fb_ff};
            dm_in    = {{32{fb_ff[31]}}, fb_ff} - {{32{pmeas_ff[31]}}, pmeas_ff};
            state_in = angle_ff ? S_WRAPE : S_MINT;
         end
         S_WRAPE: begin
            // hold here until the error sits inside +/-180
            err_in = wrap_y;
            if (wrap_y == wrap_x) begin
               state_in = S_MINT;
            end
         end
         S_MINT: begin
            md_req   = '{start: 1'b1, a: err_ff, b: {32'd0, delta_ff}, d: Ticks};
            state_in = S_ACC;
         end
         S_ACC: begin
            if (md_rsp.done) begin
               acc_in = add_r;
               if (ki_ff == 24'd0) begin
                  maxi_in  = NoCap;
                  mini_in  = 64'd0 - NoCap;
                  state_in = S_CLMP;
               end else begin
                  md_req   = '{start: 1'b1, a: hi64, b: One, d: {40'd0, ki_ff}};
                  state_in = S_MAXI;
               end
            end
         end
         S_MAXI: begin
            if (md_rsp.done) begin
               maxi_in  = md_rsp.q;
               md_req   = '{start: 1'b1, a: lo64, b: One, d: {40'd0, ki_ff}};
               state_in = S_MINI;
            end
         end
         S_MINI: begin
            if (md_rsp.done) begin
               mini_in  = md_rsp.q;
               state_in = S_CLMP;
            end
         end
         S_CLMP: begin
            // clamp once, then launch the integral term on the clamped value
            if (!wait_ff) begin
               if ($signed(acc_ff) < $signed(mini_ff)) begin
                  acc_in = mini_ff;
               end else if ($signed(acc_ff) > $signed(maxi_ff)) begin
                  acc_in = maxi_ff;
               end
               wait_in = 1'b1;
            end else begin
               md_req   = '{start: 1'b1, a: acc_ff, b: {40'd0, ki_ff}, d: One};
               state_in = S_ITRM;
            end
         end
         S_ITRM: begin
            if (md_rsp.done) begin
               if ($signed(md_rsp.q) < $signed(lo64)) begin
                  iterm_in = lo64;
               end else if ($signed(md_rsp.q) > $signed(hi64)) begin
                  iterm_in = hi64;
               end else begin
                  iterm_in = md_rsp.q;
               end
               state_in = angle_ff ? S_WRAPD : S_PROP;
               wait_in  = 1'b1;
            end
         end
         S_WRAPD: begin
            dm_in = wrap_y;
            if (wrap_y == wrap_x) begin
               state_in = S_PROP;
               wait_in  = 1'b1;
            end
         end
         S_PROP: begin
            // launch derivative divide, then the proportional product
            if (wait_ff) begin
               md_req  = '{start: 1'b1, a: dm_ff, b: Ticks, d: {32'd0, delta_ff}};
               wait_in = 1'b0;
            end else if (md_rsp.done) begin
               deriv_in = md_rsp.q;
               md_req   = '{start: 1'b1, a: err_ff, b: {40'd0, kp_ff}, d: One};
               state_in = S_DER;
            end
         end
         S_DER: begin
            if (md_rsp.done) begin
               sum_in   = add_r;
               md_req   = '{start: 1'b1, a: deriv_ff, b: {40'd0, kd_ff}, d: One};
               state_in = S_DGN;
            end
         end
         S_DGN: begin
            if (md_rsp.done) begin
               pstamp_in = now_ff;
               pmeas_in  = fb_ff;
               last_in   = clmp_r[31:0];
               rdata_in  = '{drive: clmp_r[31:0], status: ST_COMPUTED};
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            rvalid_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
         target_ff <= '0;
         lower_ff  <= {1'b1, 31'd0};
         upper_ff  <= {1'b0, {31{1'b1}}};
         enable_ff <= 1'b1;
         angle_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PROP:   kp_ff     <= csr_data[23:0];
            REG_INTEG:  ki_ff     <= csr_data[23:0];
            REG_DERIV:  kd_ff     <= csr_data[23:0];
            REG_TARGET: target_ff <= csr_data;
            REG_LOWER:  lower_ff  <= csr_data;
            REG_UPPER:  upper_ff  <= csr_data;
            REG_ENABLE: enable_ff <= csr_data[0];
            REG_ANGLE:  angle_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wait_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
         acc_ff    <= '0;
         pstamp_ff <= '0;
         pmeas_ff  <= '0;
         have_ff   <= 1'b0;
         last_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         wait_ff   <= wait_in;
         rvalid_ff <= rvalid_in;
         acc_ff    <= acc_in;
         pstamp_ff <= pstamp_in;
         pmeas_ff  <= pmeas_in;
         have_ff   <= have_in;
         last_ff   <= last_in;
      end
      fb_ff    <= fb_in;
      now_ff   <= now_in;
      delta_ff <= delta_in;
      err_ff   <= err_in;
      dm_ff    <= dm_in;
      maxi_ff  <= maxi_in;
      mini_ff  <= mini_in;
      iterm_ff <= iterm_in;
      deriv_ff <= deriv_in;
      sum_ff   <= sum_in;
      rdata_ff <= rdata_in;
   end

   assign rsp_valid   = rvalid_ff;
   assign rsp_payload = rdata_ff;

endmodule

>>> hdl/pidc_muldiv.sv
// ----------------------------------------------------------------------------
// PID shared multiply-divide unit
// Forms round(a*b/d) half away from zero, saturated to 64-bit signed.
// Multiply by 32x32 partial products, then restoring division bit by bit.
// ----------------------------------------------------------------------------
module pidc_muldiv
   import pidc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   typedef enum logic [4:0] {
      MD_IDLE = 5'b00001,
      MD_MUL  = 5'b00010,
      MD_PREP = 5'b00100,
      MD_DIV  = 5'b01000,
      MD_FIN  = 5'b10000
   } md_state_type;

   md_state_type state_ff, state_in;
   logic         neg_ff, neg_in;
   logic [63:0]  mag_ff, mag_in;
   logic [63:0]  b_ff, b_in;
   logic [63:0]  d_ff, d_in;
   logic [127:0] prod_ff, prod_in;
   logic [1:0]   pp_ff, pp_in;
   logic [64:0]  rem_ff, rem_in;
   logic [63:0]  quo_ff, quo_in;
   logic [5:0]   bit_ff, bit_in;
   logic         sat_ff, sat_in;
   logic         zero_ff, zero_in;
   logic [63:0]  q_ff, q_in;
   logic         done_ff, done_in;

   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] shifted;
   logic [127:0] rounded;
   logic [64:0]  trial;

   always_comb begin
      pa = pp_ff[1] ? mag_ff[63:32] : mag_ff[31:0];
      pb = pp_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = pa * pb;
      case ({pp_ff[1], pp_ff[0]})
         2'b00:   shifted = {64'd0, pp};
         2'b01,
         2'b10:   shifted = {32'd0, pp, 32'd0};
         default: shifted = {pp, 64'd0};
      endcase
      rounded = prod_ff + {65'd0, d_ff[63:1]};
      trial   = {rem_ff[63:0], prod_ff[127]} - {1'b0, d_ff};
   end

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      pp_in    = pp_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      sat_in   = sat_ff;
      zero_in  = zero_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               neg_in   = md_req.a[63];
               mag_in   = md_req.a[63] ? (64'd0 - md_req.a) : md_req.a;
               b_in     = md_req.b;
               d_in     = md_req.d;
               zero_in  = (md_req.d == 64'd0);
               prod_in  = '0;
               pp_in    = 2'd0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            prod_in = prod_ff + shifted;
            pp_in   = pp_ff + 2'd1;
            if (pp_ff == 2'd3) begin
               state_in = MD_PREP;
            end
         end
         MD_PREP: begin
            // add half the divisor, then check the quotient fits 64 bits
            sat_in   = (rounded[127:64] >= d_ff);
            rem_in   = {1'b0, rounded[127:64]};
            prod_in  = {rounded[63:0], 64'd0};
            quo_in   = '0;
            bit_in   = 6'd0;
            state_in = MD_DIV;
         end
         MD_DIV: begin
            if (!trial[64]) begin
               rem_in = trial;
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[63:0], prod_ff[127]};
               quo_in = {quo_ff[62:0], 1'b0};
            end
            prod_in = {prod_ff[126:0], 1'b0};
            bit_in  = bit_ff + 6'd1;
            if (bit_ff == 6'd63) begin
               state_in = MD_FIN;
            end
         end
         MD_FIN: begin
            if (zero_ff) begin
               q_in = '0;
            end else if (neg_ff) begin
               q_in = (sat_ff || quo_ff[63]) ? {1'b1, 63'd0} : (64'd0 - quo_ff);
            end else begin
               q_in = (sat_ff || quo_ff[63]) ? {1'b0, {63{1'b1}}} : quo_ff;
            end
            done_in  = 1'b1;
            state_in = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      pp_ff   <= pp_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bit_ff  <= bit_in;
      sat_ff  <= sat_in;
      zero_ff <= zero_in;
      q_ff    <= q_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.q    = q_ff;

endmodule
